FILE: design/rmm_pkg.sv
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants of the range min/max tree.
// ----------------------------------------------------------------------------
package rmm_pkg;

  localparam int LEAVES  = 1024;
  localparam int TSIZE   = 1024;
  localparam int POS_W   = 11;
  localparam int NODE_AW = 11;
  localparam int U_W     = 12;
  localparam int VAL_W   = 61;
  localparam int ANS_W   = 12;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic signed [ANS_W-1:0] ans_t;

  localparam val_t INF     = 61'sd1001001001001001001;
  localparam val_t NEG_INF = -61'sd1001001001001001001;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RANGE = 2'd1;
  localparam logic [1:0] REQ_RIGHT = 2'd2;
  localparam logic [1:0] REQ_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    OP_WRITE, OP_RANGE, OP_RIGHT, OP_LEFT, OP_BAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    pos_t     pos;
    pos_t     endb;
    val_t     val;
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_W_RD, ST_W_WR, ST_R_LOOP, ST_R_ADAT, ST_R_B, ST_R_BDAT,
    ST_S_INIT, ST_S_UP, ST_S_UPD, ST_S_DN, ST_S_DND, ST_DONE
  } bstate_t;

endpackage

FILE: design/rmm_front.sv
// ----------------------------------------------------------------------------
// rmm_front
// Accepts request items, checks bounds, classifies them and queues them.
// ----------------------------------------------------------------------------
module rmm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_req_type,
  input  rmm_pkg::pos_t in_position,
  input  rmm_pkg::pos_t in_end_bound,
  input  rmm_pkg::val_t in_value,
  input  logic          busy_clr,
  output logic          q_valid,
  output rmm_pkg::op_t  q_op,
  input  logic          q_pop
);
  import rmm_pkg::*;

  op_t        q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  op_t        op_in;
  logic       push;

  always_comb begin
    op_in.pos  = in_position;
    op_in.endb = in_end_bound;
    op_in.val  = in_value;
    unique case (in_req_type)
      REQ_WRITE: op_in.kind = (in_position >= POS_W'(LEAVES)) ? OP_BAD : OP_WRITE;
      REQ_RANGE: op_in.kind = (in_position > in_end_bound ||
                               in_end_bound > POS_W'(LEAVES)) ? OP_BAD : OP_RANGE;
      REQ_RIGHT: op_in.kind = (in_position > POS_W'(LEAVES)) ? OP_BAD : OP_RIGHT;
      default:   op_in.kind = (in_end_bound > POS_W'(LEAVES)) ? OP_BAD : OP_LEFT;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2) || busy_clr;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: design/rmm_back.sv
// ----------------------------------------------------------------------------
// rmm_back
// Tree engine: node memories, tree walk sequencer and result register.
// ----------------------------------------------------------------------------
module rmm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  rmm_pkg::op_t  q_op,
  output logic          q_pop,
  output logic          busy_clr,
  output logic          out_valid,
  input  logic          out_stall,
  output rmm_pkg::val_t out_range_min,
  output rmm_pkg::val_t out_range_max,
  output rmm_pkg::ans_t out_pos_by_min,
  output rmm_pkg::ans_t out_pos_by_max,
  output logic          out_bad_request
);
  import rmm_pkg::*;

  val_t min_mem [2**NODE_AW];
  val_t max_mem [2**NODE_AW];

  bstate_t            state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [U_W-1:0]     u_r, u_nxt, a_r, a_nxt, b_r, b_nxt;
  val_t               cur_min_r, cur_min_nxt, cur_max_r, cur_max_nxt;
  ans_t               pmin_r, pmin_nxt, pmax_r, pmax_nxt;
  logic               kind_r, kind_nxt;
  logic [NODE_AW-1:0] clr_r, clr_nxt;
  val_t               rd_min_r, rd_max_r;
  logic [NODE_AW-1:0] rd_addr, wr_addr;
  logic               we;
  val_t               wr_min, wr_max;

  logic               out_valid_r, out_valid_nxt, bad_r, bad_nxt;
  val_t               omin_r, omin_nxt, omax_r, omax_nxt;
  ans_t               opmin_r, opmin_nxt, opmax_r, opmax_nxt;

  logic               right, sat, climb, desc, pow2, empty_ok, init_none, out_free;
  logic               res_set;
  ans_t               res_val, none_val;
  logic [U_W-1:0]     step, u_dn;
  logic [U_W:0]       ans_w;
  pos_t               start;
  val_t               cmb_min, cmb_max;

  assign right     = (op_r.kind == OP_RIGHT);
  assign sat       = kind_r ? (op_r.val <= rd_max_r) : (op_r.val >= rd_min_r);
  assign climb     = right ? u_r[0] : (u_r[0] || u_r == U_W'(2));
  assign step      = right ? u_r + U_W'(1) : u_r - U_W'(1);
  assign pow2      = ((step & (step - U_W'(1))) == '0);
  assign desc      = right ? (u_r < U_W'(TSIZE)) : (u_r <= U_W'(TSIZE));
  assign ans_w     = right ? {1'b0, u_r} - (U_W+1)'(TSIZE) + (U_W+1)'(1)
                           : {1'b0, u_r} - (U_W+1)'(TSIZE) - (U_W+1)'(1);
  assign start     = right ? op_r.pos : op_r.endb;
  assign empty_ok  = kind_r ? (op_r.val <= NEG_INF) : (op_r.val >= INF);
  assign init_none = right ? (op_r.pos >= POS_W'(LEAVES)) : (op_r.endb == '0);
  assign none_val  = right ? ANS_W'(LEAVES + 1) : -ANS_W'(1);
  assign u_dn      = {u_r[U_W-2:0], 1'b0};
  assign cmb_min   = (rd_min_r < cur_min_r) ? rd_min_r : cur_min_r;
  assign cmb_max   = (rd_max_r > cur_max_r) ? rd_max_r : cur_max_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign busy_clr = (state_r == ST_CLR);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:    if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_WRITE:          state_nxt = ST_W_RD;
            OP_RANGE:          state_nxt = ST_R_LOOP;
            OP_RIGHT, OP_LEFT: state_nxt = ST_S_INIT;
            default:           state_nxt = ST_DONE;
          endcase
        end
      end
      ST_W_RD:   state_nxt = ST_W_WR;
      ST_W_WR:   state_nxt = (u_r[U_W-1:1] == (U_W-1)'(1)) ? ST_DONE : ST_W_RD;
      ST_R_LOOP: state_nxt = (a_r < b_r) ? (a_r[0] ? ST_R_ADAT : ST_R_B) : ST_DONE;
      ST_R_ADAT: state_nxt = ST_R_B;
      ST_R_B:    state_nxt = b_r[0] ? ST_R_BDAT : ST_R_LOOP;
      ST_R_BDAT: state_nxt = ST_R_LOOP;
      ST_S_INIT: begin
        if (empty_ok || init_none) state_nxt = kind_r ? ST_DONE : ST_S_INIT;
        else                       state_nxt = ST_S_UP;
      end
      ST_S_UP:   state_nxt = climb ? ST_S_UPD : ST_S_UP;
      ST_S_UPD: begin
        if (sat)       state_nxt = ST_S_DN;
        else if (pow2) state_nxt = kind_r ? ST_DONE : ST_S_INIT;
        else           state_nxt = ST_S_UP;
      end
      ST_S_DN:   state_nxt = desc ? ST_S_DND : (kind_r ? ST_DONE : ST_S_INIT);
      ST_S_DND:  state_nxt = ST_S_DN;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt      = op_r;
    u_nxt       = u_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    cur_min_nxt = cur_min_r;
    cur_max_nxt = cur_max_r;
    pmin_nxt    = pmin_r;
    pmax_nxt    = pmax_r;
    kind_nxt    = kind_r;
    clr_nxt     = clr_r;
    rd_addr     = '0;
    we          = 1'b0;
    wr_addr     = '0;
    wr_min      = cmb_min;
    wr_max      = cmb_max;
    res_set     = 1'b0;
    res_val     = none_val;
    out_valid_nxt = out_valid_r && out_stall;
    omin_nxt    = omin_r;
    omax_nxt    = omax_r;
    opmin_nxt   = opmin_r;
    opmax_nxt   = opmax_r;
    bad_nxt     = bad_r;
    unique case (state_r)
      ST_CLR: begin
        we      = 1'b1;
        wr_addr = clr_r;
        wr_min  = INF;
        wr_max  = NEG_INF;
        clr_nxt = clr_r + NODE_AW'(1);
      end
      ST_IDLE: begin
        if (q_valid) begin
          op_nxt   = q_op;
          pmin_nxt = '0;
          pmax_nxt = '0;
          kind_nxt = 1'b0;
          if (q_op.kind == OP_WRITE) begin
            u_nxt       = {1'b0, q_op.pos} + U_W'(TSIZE);
            we          = 1'b1;
            wr_addr     = u_nxt[NODE_AW-1:0];
            wr_min      = q_op.val;
            wr_max      = q_op.val;
            cur_min_nxt = q_op.val;
            cur_max_nxt = q_op.val;
          end else begin
            a_nxt       = {1'b0, q_op.pos} + U_W'(TSIZE);
            b_nxt       = {1'b0, q_op.endb} + U_W'(TSIZE);
            cur_min_nxt = INF;
            cur_max_nxt = NEG_INF;
          end
        end
      end
      ST_W_RD: rd_addr = u_r[NODE_AW-1:0] ^ NODE_AW'(1);
      ST_W_WR: begin
        we          = 1'b1;
        wr_addr     = u_r[U_W-1:1];
        cur_min_nxt = cmb_min;
        cur_max_nxt = cmb_max;
        u_nxt       = {1'b0, u_r[U_W-1:1]};
      end
      ST_R_LOOP: rd_addr = a_r[NODE_AW-1:0];
      ST_R_ADAT: begin
        cur_min_nxt = cmb_min;
        cur_max_nxt = cmb_max;
        a_nxt       = a_r + U_W'(1);
      end
      ST_R_B: begin
        if (b_r[0]) begin
          b_nxt   = b_r - U_W'(1);
          rd_addr = b_nxt[NODE_AW-1:0];
        end else begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
        end
      end
      ST_R_BDAT: begin
        cur_min_nxt = cmb_min;
        cur_max_nxt = cmb_max;
        a_nxt       = a_r >> 1;
        b_nxt       = b_r >> 1;
      end
      ST_S_INIT: begin
        if (empty_ok) begin
          res_set = 1'b1;
          res_val = ANS_W'(start);
        end else if (init_none) begin
          res_set = 1'b1;
        end else begin
          u_nxt = {1'b0, start} + U_W'(TSIZE);
        end
      end
      ST_S_UP: begin
        if (climb) rd_addr = right ? u_r[NODE_AW-1:0] : u_r[NODE_AW-1:0] - NODE_AW'(1);
        else       u_nxt = u_r >> 1;
      end
      ST_S_UPD: begin
        if (!sat) begin
          u_nxt   = step;
          res_set = pow2;
        end
      end
      ST_S_DN: begin
        if (desc) begin
          u_nxt   = u_dn;
          rd_addr = right ? u_dn[NODE_AW-1:0] : u_dn[NODE_AW-1:0] - NODE_AW'(1);
        end else begin
          res_set = 1'b1;
          res_val = ans_w[ANS_W-1:0];
        end
      end
      ST_S_DND: if (!sat) u_nxt = step;
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          omin_nxt  = (op_r.kind == OP_RANGE) ? cur_min_r : '0;
          omax_nxt  = (op_r.kind == OP_RANGE) ? cur_max_r : '0;
          opmin_nxt = (op_r.kind == OP_RIGHT || op_r.kind == OP_LEFT) ? pmin_r : '0;
          opmax_nxt = (op_r.kind == OP_RIGHT || op_r.kind == OP_LEFT) ? pmax_r : '0;
          bad_nxt   = (op_r.kind == OP_BAD);
        end
      end
      default: ;
    endcase
    if (res_set) begin
      if (kind_r) pmax_nxt = res_val;
      else        pmin_nxt = res_val;
      kind_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      min_mem[wr_addr] <= wr_min;
      max_mem[wr_addr] <= wr_max;
    end
    rd_min_r <= min_mem[rd_addr];
    rd_max_r <= max_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    u_r       <= u_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    cur_min_r <= cur_min_nxt;
    cur_max_r <= cur_max_nxt;
    pmin_r    <= pmin_nxt;
    pmax_r    <= pmax_nxt;
    kind_r    <= kind_nxt;
    omin_r    <= omin_nxt;
    omax_r    <= omax_nxt;
    opmin_r   <= opmin_nxt;
    opmax_r   <= opmax_nxt;
    bad_r     <= bad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_range_min   = omin_r;
  assign out_range_max   = omax_r;
  assign out_pos_by_min  = opmin_r;
  assign out_pos_by_max  = opmax_r;
  assign out_bad_request = bad_r;

endmodule

FILE: design/range_min_max_tree.sv
// Throughput: one item at a time through the engine; the next item leaves the
// queue only after the previous result has been taken into the output register.
// Reset: synchronous; afterwards a clearing pass writes all 2048 entries of the
// node memories with the identities, during which no item is accepted.
// ----------------------------------------------------------------------------
// range_min_max_tree
// Segment tree over signed leaves with point writes, range min/max queries
// and rightward/leftward threshold searches.
// ----------------------------------------------------------------------------
module range_min_max_tree (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_req_type,
  input  rmm_pkg::pos_t in_position,
  input  rmm_pkg::pos_t in_end_bound,
  input  rmm_pkg::val_t in_value,
  output logic          out_valid,
  input  logic          out_stall,
  output rmm_pkg::val_t out_range_min,
  output rmm_pkg::val_t out_range_max,
  output rmm_pkg::ans_t out_pos_by_min,
  output rmm_pkg::ans_t out_pos_by_max,
  output logic          out_bad_request
);
  import rmm_pkg::*;

  logic busy_clr, q_valid, q_pop;
  op_t  q_op;

  rmm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_position  (in_position),
    .in_end_bound (in_end_bound),
    .in_value     (in_value),
    .busy_clr     (busy_clr),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop)
  );

  rmm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_pop           (q_pop),
    .busy_clr        (busy_clr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_range_min   (out_range_min),
    .out_range_max   (out_range_max),
    .out_pos_by_min  (out_pos_by_min),
    .out_pos_by_max  (out_pos_by_max),
    .out_bad_request (out_bad_request)
  );

endmodule

FILE: dv/rmm_checker.sv
// ----------------------------------------------------------------------------
// rmm_checker
// Watches both channels of the range min/max tree. Keeps its own copy of the
// min/max tree, predicts the answer to every accepted request and compares
// each result, field by field, with the oldest pending answer.
// ----------------------------------------------------------------------------
module rmm_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [1:0]    in_req_type,
  input  rmm_pkg::pos_t in_position,
  input  rmm_pkg::pos_t in_end_bound,
  input  rmm_pkg::val_t in_value,
  input  logic          out_valid,
  input  logic          out_stall,
  input  rmm_pkg::val_t out_range_min,
  input  rmm_pkg::val_t out_range_max,
  input  rmm_pkg::ans_t out_pos_by_min,
  input  rmm_pkg::ans_t out_pos_by_max,
  input  logic          out_bad_request,
  output int            errors,
  output int            pending,
  output int            checked
);
  import rmm_pkg::*;

  typedef struct {
    longint rmin;
    longint rmax;
    int     pmin;
    int     pmax;
    bit     bad;
  } answer_t;

  longint  tree_min [0:4095];
  longint  tree_max [0:4095];
  answer_t answers[$];

  assign pending = answers.size();

  function automatic longint nmin(int u);
    return u < 4096 ? tree_min[u] : longint'(INF);
  endfunction

  function automatic longint nmax(int u);
    return u < 4096 ? tree_max[u] : longint'(NEG_INF);
  endfunction

  // kind 0: span min <= target, kind 1: span max >= target
  function automatic bit meets(int kind, int u, longint t);
    return kind == 0 ? t >= nmin(u) : t <= nmax(u);
  endfunction

  function automatic bit empty_meets(int kind, longint t);
    return kind == 0 ? t >= longint'(INF) : t <= longint'(NEG_INF);
  endfunction

  function automatic int find_right(int kind, int a, longint t);
    int u;
    if (empty_meets(kind, t)) return a;
    if (a >= LEAVES) return LEAVES + 1;
    u = a + TSIZE;
    forever begin
      if (u & 1) begin
        if (meets(kind, u, t)) begin
          while (u < TSIZE) begin
            u = u << 1;
            if (!meets(kind, u, t)) u++;
          end
          return u - TSIZE + 1;
        end
        u++;
        if ((u & (u - 1)) == 0) return LEAVES + 1;
      end
      u = u >> 1;
    end
  endfunction

  function automatic int find_left(int kind, int b, longint t);
    int u;
    if (empty_meets(kind, t)) return b;
    if (b == 0) return -1;
    u = b + TSIZE;
    forever begin
      if ((u & 1) || u == 2) begin
        if (meets(kind, u - 1, t)) begin
          while (u <= TSIZE) begin
            u = u << 1;
            if (!meets(kind, u - 1, t)) u--;
          end
          return u - TSIZE - 1;
        end
        u--;
        if ((u & (u - 1)) == 0) return -1;
      end
      u = u >> 1;
    end
  endfunction

  function automatic answer_t tree_apply(logic [1:0] req, int p, int e, longint v);
    answer_t r;
    int a, b, u;
    r = '{0, 0, 0, 0, 0};
    case (req)
      REQ_WRITE: begin
        if (p >= LEAVES) r.bad = 1;
        else begin
          u = p + TSIZE;
          tree_min[u] = v;
          tree_max[u] = v;
          for (u = u >> 1; u != 0; u = u >> 1) begin
            tree_min[u] = tree_min[2*u] < tree_min[2*u+1] ? tree_min[2*u] : tree_min[2*u+1];
            tree_max[u] = tree_max[2*u] > tree_max[2*u+1] ? tree_max[2*u] : tree_max[2*u+1];
          end
        end
      end
      REQ_RANGE: begin
        if (p > e || e > LEAVES) r.bad = 1;
        else begin
          r.rmin = INF;
          r.rmax = NEG_INF;
          for (a = p + TSIZE, b = e + TSIZE; a < b; a = a >> 1, b = b >> 1) begin
            if (a & 1) begin
              if (tree_min[a] < r.rmin) r.rmin = tree_min[a];
              if (tree_max[a] > r.rmax) r.rmax = tree_max[a];
              a++;
            end
            if (b & 1) begin
              b--;
              if (tree_min[b] < r.rmin) r.rmin = tree_min[b];
              if (tree_max[b] > r.rmax) r.rmax = tree_max[b];
            end
          end
        end
      end
      REQ_RIGHT: begin
        if (p > LEAVES) r.bad = 1;
        else begin
          r.pmin = find_right(0, p, v);
          r.pmax = find_right(1, p, v);
        end
      end
      default: begin
        if (e > LEAVES) r.bad = 1;
        else begin
          r.pmin = find_left(0, e, v);
          r.pmax = find_left(1, e, v);
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < 4096; i++) begin
        tree_min[i] = INF;
        tree_max[i] = NEG_INF;
      end
      answers.delete();
      errors  <= 0;
      checked <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          $error("result item with no request pending");
          errors <= errors + 1;
        end else begin
          want = answers.pop_front();
          checked <= checked + 1;
          if (out_range_min !== val_t'(want.rmin) || out_range_max !== val_t'(want.rmax) ||
              out_pos_by_min !== ans_t'(want.pmin) || out_pos_by_max !== ans_t'(want.pmax) ||
              out_bad_request !== want.bad)
            errors <= errors + 1;
          if (out_range_min !== val_t'(want.rmin))
            $error("range_min exp %0d got %0d", val_t'(want.rmin), out_range_min);
          if (out_range_max !== val_t'(want.rmax))
            $error("range_max exp %0d got %0d", val_t'(want.rmax), out_range_max);
          if (out_pos_by_min !== ans_t'(want.pmin))
            $error("pos_by_min exp %0d got %0d", ans_t'(want.pmin), out_pos_by_min);
          if (out_pos_by_max !== ans_t'(want.pmax))
            $error("pos_by_max exp %0d got %0d", ans_t'(want.pmax), out_pos_by_max);
          if (out_bad_request !== want.bad)
            $error("bad_request exp %0d got %0d", want.bad, out_bad_request);
        end
      end
      if (in_valid && !in_stall)
        answers.push_back(tree_apply(in_req_type, in_position, in_end_bound,
                                     longint'(in_value)));
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random requests into the range min/max tree with
// random idling on both channels and long back-pressure, and reports the
// verdict from the checker's mismatch and pending-answer counts.
// ----------------------------------------------------------------------------
module tb_top;
  import rmm_pkg::*;

  localparam int HANG_LIMIT = 20000;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_stall;
  logic [1:0] in_req_type = REQ_WRITE;
  pos_t       in_position = '0;
  pos_t       in_end_bound = '0;
  val_t       in_value = '0;
  logic       out_valid;
  logic       out_stall = 0;
  val_t       out_range_min, out_range_max;
  ans_t       out_pos_by_min, out_pos_by_max;
  logic       out_bad_request;
  int         errors, pending, checked;

  int idle_in = 0;
  int idle_out = 0;
  int hold_off = 0;
  int quiet = 0;
  int sent = 0;

  always #4 clk = ~clk;

  range_min_max_tree dut (.*);

  rmm_checker chk (.*);

  // receiver: random stalls plus a counted long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off  <= hold_off - 1;
    end else begin
      out_stall <= $urandom_range(99) < idle_out;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= HANG_LIMIT) begin
      $display("hang: no item moved for %0d cycles", HANG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(logic [1:0] req, int p, int e, val_t v);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid     <= 1;
    in_req_type  <= req;
    in_position  <= pos_t'(p);
    in_end_bound <= pos_t'(e);
    in_value     <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  function automatic val_t any_value();
    case ($urandom_range(3))
      0: return val_t'({$urandom, $urandom});
      1: return val_t'($signed($urandom_range(40)) - 20);
      2: return $urandom_range(1) ? INF : NEG_INF;
      default: return val_t'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic int any_pos();
    return $urandom_range(19) == 0 ? $urandom_range(2047) : $urandom_range(LEAVES);
  endfunction

  task automatic random_items(int n);
    int p, e;
    repeat (n) begin
      p = any_pos();
      e = any_pos();
      case ($urandom_range(9))
        0, 1, 2, 3: send(REQ_WRITE, $urandom_range(19) == 0 ? any_pos() : $urandom_range(LEAVES - 1),
                         0, any_value());
        4, 5: send(REQ_RANGE, p < e || $urandom_range(9) == 0 ? p : e,
                   p < e || $urandom_range(9) == 0 ? e : p, 0);
        6, 7: send(REQ_RIGHT, p, e, any_value());
        default: send(REQ_LEFT, p, e, any_value());
      endcase
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed: identities, extremes, bad bounds, trivial targets
    send(REQ_RANGE, 0, LEAVES, 0);
    send(REQ_RIGHT, 0, 0, 0);
    send(REQ_LEFT, 0, LEAVES, 0);
    send(REQ_WRITE, 0, 0, val_t'(61'h0FFF_FFFF_FFFF_FFFF));
    send(REQ_WRITE, LEAVES - 1, 2047, val_t'(61'h1000_0000_0000_0000));
    send(REQ_WRITE, 512, 0, INF);
    send(REQ_WRITE, 513, 0, NEG_INF);
    send(REQ_WRITE, LEAVES, 0, 5);
    send(REQ_WRITE, 2047, 0, 5);
    send(REQ_RANGE, 0, LEAVES, 0);
    send(REQ_RANGE, 7, 7, 0);
    send(REQ_RANGE, 8, 7, 0);
    send(REQ_RANGE, 0, LEAVES + 1, 0);
    send(REQ_RANGE, 1, LEAVES - 1, 0);
    send(REQ_RIGHT, 0, 0, INF);
    send(REQ_RIGHT, 3, 0, NEG_INF);
    send(REQ_RIGHT, LEAVES, 0, 0);
    send(REQ_RIGHT, LEAVES + 1, 0, 0);
    send(REQ_RIGHT, 1, 0, 0);
    send(REQ_LEFT, 0, 0, 0);
    send(REQ_LEFT, 0, LEAVES, 0);
    send(REQ_LEFT, 0, LEAVES - 1, INF);
    send(REQ_LEFT, 0, LEAVES + 1, 0);
    send(REQ_LEFT, 0, 2047, 0);
    drain();

    idle_in  = 8;
    idle_out = 69;
    random_items(300);
    hold_off <= 400;
    random_items(300);
    drain();

    idle_in  = 69;
    idle_out = 8;
    random_items(600);
    drain();

    idle_in  = 0;
    idle_out = 0;
    random_items(600);
    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d requests, %0d results checked, %0d mismatches",
             sent, checked, errors);
    if (errors == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
